// ===== rtl/rtpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpm_pkg: shared definitions for the route table prefix match block
// Command and status codes, the stored route entry layout and default sizes.
// ----------------------------------------------------------------------------
package rtpm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DIRECT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PROT   = 3'd5;

    // One route as it sits in the table memory.
    typedef struct packed {
        logic              direct;
        logic [ADDR_W-1:0] hop;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] dest;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/rtpm_ram.sv =====
// ----------------------------------------------------------------------------
// rtpm_ram: generic single-clock RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module rtpm_ram #(
    parameter int WIDTH = rtpm_pkg::ENTRY_W,
    parameter int DEPTH = rtpm_pkg::DEFAULT_TABLE_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/route_table_prefix_match.sv =====
// ----------------------------------------------------------------------------
// route_table_prefix_match: IPv4 route table with first-match lookup
// Routes are kept in one RAM sorted by descending mask and are searched,
// inserted and deleted by a small sequencer working one entry per cycle.
// ----------------------------------------------------------------------------
// The block holds up to TABLE_DEPTH routes in a single table RAM, ordered by
// mask value from largest to smallest, and handles one command transaction at
// a time. A lookup reads the table front to back, one entry per cycle, and
// returns the first route whose mask applied to the address gives its
// destination. An add first scans for the insertion point the same way and
// stops there, then moves every later route one place back (one read and one
// write per cycle) and writes the new route. A remove checks the route at the
// given position, then moves the routes behind it one place forward. in_ready
// is high only while the sequencer is idle. Each command yields exactly one
// result transaction, held in an output register so a new command can be
// taken while an earlier result still waits for out_ready. The table contents
// are not cleared at reset; only the route count is, and no entry beyond the
// count is ever read.
// ----------------------------------------------------------------------------
module route_table_prefix_match #(
    parameter int TABLE_DEPTH = rtpm_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rtpm_pkg::CMD_W-1:0]    cmd,
    input  logic [rtpm_pkg::ADDR_W-1:0]   addr,
    input  logic [rtpm_pkg::ADDR_W-1:0]   mask,
    input  logic [rtpm_pkg::ADDR_W-1:0]   next_hop,
    input  logic                          direct,
    input  logic [rtpm_pkg::POS_W-1:0]    position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rtpm_pkg::STATUS_W-1:0] status,
    output logic [rtpm_pkg::ADDR_W-1:0]   hop_addr
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RCHK  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Latched command transaction.
    logic [rtpm_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [rtpm_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [rtpm_pkg::ADDR_W-1:0] mask_reg, mask_next;
    logic [rtpm_pkg::ADDR_W-1:0] hop_reg, hop_next;
    logic                        direct_reg, direct_next;
    logic [rtpm_pkg::POS_W-1:0]  pos_reg, pos_next;

    // Table bookkeeping.
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          dv_reg, dv_next;
    logic [CW-1:0] at_reg, at_next;

    // Entry mover: reads src and writes the entry one place up or down.
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          up_reg, up_next;
    logic          issue_reg, issue_next;
    logic          pend_reg, pend_next;

    // Result staging and output register.
    logic [rtpm_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [rtpm_pkg::ADDR_W-1:0]   res_hop_reg, res_hop_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rtpm_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [rtpm_pkg::ADDR_W-1:0]   hop_addr_reg, hop_addr_next;

    // Table RAM ports.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [rtpm_pkg::ENTRY_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [rtpm_pkg::ENTRY_W-1:0] ram_rdata;
    rtpm_pkg::entry_t            rd_entry;
    rtpm_pkg::entry_t            new_entry;

    logic in_fire;
    logic scan_hit;
    logic scan_last;
    logic add_go;
    logic [CW-1:0] add_at;

    rtpm_ram #(
        .WIDTH (rtpm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = rtpm_pkg::entry_t'(ram_rdata);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hop_addr  = hop_addr_reg;

    always_comb
    begin
        new_entry.direct = direct_reg;
        new_entry.hop    = hop_reg;
        new_entry.mask   = mask_reg;
        new_entry.dest   = addr_reg;
    end

    // Shared compare unit: the lookup match test or the insertion point test,
    // applied to the entry read in the previous cycle.
    always_comb
    begin
        if (cmd_reg == rtpm_pkg::CMD_LOOKUP)
        begin
            scan_hit = ((addr_reg & rd_entry.mask) == rd_entry.dest);
        end
        else
        begin
            scan_hit = (rd_entry.mask < mask_reg);
        end
        scan_last = (CW'(cmp_idx_reg + 1'b1) == count_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        hop_next        = hop_reg;
        direct_next     = direct_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        dv_next         = 1'b0;
        at_next         = at_reg;
        src_next        = src_reg;
        last_next       = last_reg;
        dst_next        = dst_reg;
        up_next         = up_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        res_status_next = res_status_reg;
        res_hop_next    = res_hop_reg;
        ram_we          = 1'b0;
        ram_waddr       = dst_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[AW-1:0];
        add_go          = 1'b0;
        add_at          = count_reg;

        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        hop_addr_next  = hop_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next        = cmd;
                    addr_next       = addr;
                    mask_next       = mask;
                    hop_next        = next_hop;
                    direct_next     = direct;
                    pos_next        = position;
                    idx_next        = '0;
                    res_status_next = rtpm_pkg::ST_OK;
                    res_hop_next    = '0;
                    state_next      = S_RESP;
                    case (cmd)
                        rtpm_pkg::CMD_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = rtpm_pkg::ST_MISS;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        rtpm_pkg::CMD_ADD:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status_next = rtpm_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                at_next    = '0;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        rtpm_pkg::CMD_REMOVE:
                        begin
                            if ((position == '0) || (32'(position) > 32'(count_reg)))
                            begin
                                res_status_next = rtpm_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(position - 1'b1);
                                state_next = S_RCHK;
                            end
                        end
                        default:
                        begin
                            res_status_next = rtpm_pkg::ST_OK;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads run one ahead of the compare.
                if (idx_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = idx_reg[AW-1:0];
                    idx_next     = CW'(idx_reg + 1'b1);
                    cmp_idx_next = idx_reg;
                    dv_next      = 1'b1;
                end
                if (dv_reg)
                begin
                    if (scan_hit)
                    begin
                        if (cmd_reg == rtpm_pkg::CMD_LOOKUP)
                        begin
                            res_status_next = rd_entry.direct ? rtpm_pkg::ST_DIRECT
                                                              : rtpm_pkg::ST_OK;
                            res_hop_next    = rd_entry.direct ? '0 : rd_entry.hop;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            add_go = 1'b1;
                            add_at = cmp_idx_reg;
                        end
                    end
                    else if (scan_last)
                    begin
                        if (cmd_reg == rtpm_pkg::CMD_LOOKUP)
                        begin
                            res_status_next = rtpm_pkg::ST_MISS;
                            res_hop_next    = '0;
                            state_next      = S_RESP;
                        end
                        else
                        begin
                            add_go = 1'b1;
                            add_at = count_reg;
                        end
                    end
                end
                if (add_go)
                begin
                    at_next = add_at;
                    dv_next = 1'b0;
                    if (add_at == count_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        // Move entries at..count-1 one place back, last one first.
                        src_next   = AW'(count_reg - 1'b1);
                        last_next  = AW'(add_at);
                        up_next    = 1'b1;
                        issue_next = 1'b1;
                        state_next = S_MOVE;
                    end
                end
            end

            S_MOVE:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (issue_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_reg;
                    pend_next = 1'b1;
                    dst_next  = up_reg ? AW'(src_reg + 1'b1) : AW'(src_reg - 1'b1);
                    src_next  = up_reg ? AW'(src_reg - 1'b1) : AW'(src_reg + 1'b1);
                    if (src_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                end
                else if (pend_reg)
                begin
                    if (up_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        count_next      = CW'(count_reg - 1'b1);
                        res_status_next = rtpm_pkg::ST_OK;
                        state_next      = S_RESP;
                    end
                end
            end

            S_WRITE:
            begin
                ram_we          = 1'b1;
                ram_waddr       = at_reg[AW-1:0];
                ram_wdata       = new_entry;
                count_next      = CW'(count_reg + 1'b1);
                res_status_next = rtpm_pkg::ST_OK;
                state_next      = S_RESP;
            end

            S_RCHK:
            begin
                if (rd_entry.direct)
                begin
                    res_status_next = rtpm_pkg::ST_PROT;
                    state_next      = S_RESP;
                end
                else if (32'(pos_reg) == 32'(count_reg))
                begin
                    count_next      = CW'(count_reg - 1'b1);
                    res_status_next = rtpm_pkg::ST_OK;
                    state_next      = S_RESP;
                end
                else
                begin
                    // Move entries position..count-1 one place forward.
                    src_next   = AW'(pos_reg);
                    last_next  = AW'(count_reg - 1'b1);
                    up_next    = 1'b0;
                    issue_next = 1'b1;
                    state_next = S_MOVE;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    hop_addr_next  = res_hop_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dv_reg        <= 1'b0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dv_reg        <= dv_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        mask_reg       <= mask_next;
        hop_reg        <= hop_next;
        direct_reg     <= direct_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        at_reg         <= at_next;
        src_reg        <= src_next;
        last_reg       <= last_next;
        dst_reg        <= dst_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_hop_reg    <= res_hop_next;
        status_reg     <= status_next;
        hop_addr_reg   <= hop_addr_next;
    end

`ifndef SYNTHESIS
    // The route count never exceeds the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("route count exceeds table depth");

    // The count only ever steps by one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == CW'($past(count_reg) + 1'b1)) ||
             (count_reg == CW'($past(count_reg) - 1'b1))))
        else $error("route count jumped");

    // An add into a full table leaves the count alone.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (cmd == rtpm_pkg::CMD_ADD) && (count_reg == FULL_COUNT))
            |=> (count_reg == FULL_COUNT))
        else $error("add into full table changed count");

    // The mover never reads and writes the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("table read and write collide");

    // No table write while the sequencer is idle.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table written while idle");
`endif

endmodule
